/* rtl/bdq_pkg.sv */
// ============================================================================
// bdq_pkg: shared types and constants of the bounded double-ended queue
// Field widths, operation codes and the empty-queue marker word.
// ============================================================================
`default_nettype none

package bdq_pkg;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;

  // Value reported for front and rear while the queue is empty
  localparam logic signed [VALUE_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_REPORT     = 3'd4
  } op_t;

endpackage

`default_nettype wire

/* rtl/bdq_if.sv */
// ============================================================================
// bdq_if: request and result channels of the bounded double-ended queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic                      is_empty;
  logic                      is_full;
  logic [CNT_W-1:0]          entry_total;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, output entry_total, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, input entry_total, output ready);
endinterface

`default_nettype wire

/* rtl/bdq_ring.sv */
// ============================================================================
// bdq_ring: entry storage of the queue
// One write port and two registered read ports over DEPTH signed words.
// ============================================================================
`default_nettype none

module bdq_ring import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic signed [VALUE_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic signed [VALUE_W-1:0]       rdata_a,
  output logic signed [VALUE_W-1:0]       rdata_b
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // Write one entry, read two through registered outputs
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/bounded_double_ended_queue_top.sv */
// ============================================================================
// bounded_double_ended_queue_top: bounded double-ended queue of signed words
// Ring of DEPTH entries with front index and entry count; one result a request.
// ============================================================================
// Each request performs push front, push rear, pop front, pop rear or a plain
// report (unused op codes report too) and yields one result describing the
// queue afterwards: success flag, front and rear words (-1 when empty), empty
// and full flags and the entry count. A push onto a full queue and a pop from
// an empty one fail and change nothing. The usable size is capacity,
// saturated at DEPTH; a capacity of zero keeps the queue full. A request passes
// through three steps: updating the pointers and writing the ring memory, the
// registered two-port read of the front and rear entries, and loading the
// result register; the next request is taken once that result register is
// loaded, so a stalled result holds it back. capacity may only
// be written while no request is in progress.
// ============================================================================
`default_nettype none

module bounded_double_ended_queue_top import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  bdq_req_if.sink                req,
  bdq_rsp_if.source              rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Add an offset below DEPTH to a ring index, wrapping once
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t           state, state_next;
  logic [CNT_W-1:0] capacity;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ok, ok_next;

  logic             accept;
  logic             full_now;
  logic [CNT_W-1:0] limit;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rear_addr;
  logic [CNT_W-1:0] rear_offs;
  logic signed [VALUE_W-1:0] rd_front, rd_rear;
  logic             rsp_load;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // Saturate capacity at the ring depth
  assign limit    = (SUM_W'(capacity) > DEPTH_S) ? CNT_W'(DEPTH) : capacity;
  assign full_now = (count >= limit);

  // Work out the new pointers and the ring write for the request
  always_comb begin
    front_next = front;
    count_next = count;
    ok_next    = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = front;
    case (req.op)
      OP_PUSH_FRONT: begin
        if (full_now) begin
          ok_next = 1'b0;
        end else begin
          front_next = (front == '0) ? LAST_IDX : front - 1'b1;
          count_next = count + 1'b1;
          wr_en      = accept;
          wr_addr    = front_next;
        end
      end
      OP_PUSH_REAR: begin
        if (full_now) begin
          ok_next = 1'b0;
        end else begin
          count_next = count + 1'b1;
          wr_en      = accept;
          wr_addr    = ring_add(front, count);
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          ok_next = 1'b0;
        end else begin
          count_next = count - 1'b1;
          if (count_next != '0) begin
            front_next = ring_add(front, CNT_W'(1));
          end
        end
      end
      OP_POP_REAR: begin
        if (count == '0) begin
          ok_next = 1'b0;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        ok_next = 1'b1;
      end
    endcase
  end

  // Locate the rear entry from the updated pointers
  assign rear_offs = (count == '0) ? '0 : count - 1'b1;
  assign rear_addr = ring_add(front, rear_offs);

  bdq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (req.value),
    .raddr_a (front),
    .raddr_b (rear_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  // Advance through update, read and result load
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CNT_W'(16);
      front    <= '0;
      count    <= '0;
      ok       <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        front <= front_next;
        count <= count_next;
        ok    <= ok_next;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.ok          <= ok;
      rsp.front_value <= (count == '0) ? EMPTY_WORD : rd_front;
      rsp.rear_value  <= (count == '0) ? EMPTY_WORD : rd_rear;
      rsp.is_empty    <= (count == '0);
      rsp.is_full     <= full_now;
      rsp.entry_total <= count;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(count) <= DEPTH_S)
    else $error("entry count exceeds ring depth");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted request did not move to the read step");

  a_read_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_DONE) && !req.ready)
    else $error("read step did not move to result load");

  a_pointers_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count) && $stable(front))
    else $error("pointers changed without a request");
`endif

endmodule

`default_nettype wire

/* sim/tb_bounded_double_ended_queue_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_bounded_double_ended_queue_top: self-checking bench for the deque block
// Runs a short table of directed requests, then random request mixes over a
// series of capacity settings. A shadow ring tracks the deque state and
// predicts each result, which is checked field by field in arrival order.
// ============================================================================

module tb_bounded_double_ended_queue_top;
  import bdq_pkg::*;

  localparam int RING_DEPTH      = 16;
  localparam int IDX_W           = $clog2(RING_DEPTH);
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int IDLE_PCT        = 27;
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 152;
  localparam int STEADY_PHASE    = 4;
  localparam int PRESSURE_PHASE  = 7;
  localparam int CAP_RANDOM      = 32;
  localparam int DIRECTED_ROWS   = 24;

  // Op codes outside the enum; the block treats them as a plain report
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic                      is_empty;
    logic                      is_full;
    logic [CNT_W-1:0]          entry_total;
  } deque_status_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic                      has_want;
    deque_status_t             want;
  } directed_row_t;

  localparam deque_status_t NO_WANT     = '0;
  localparam deque_status_t EMPTY_OK    = '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 5'd0};
  localparam deque_status_t EMPTY_FAIL  = '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 5'd0};
  localparam deque_status_t ONE_MAX     = '{1'b1, WORD_MAX, WORD_MAX, 1'b0, 1'b0, 5'd1};
  localparam deque_status_t MAX_AND_MIN = '{1'b1, WORD_MAX, WORD_MIN, 1'b0, 1'b0, 5'd2};

  // Directed requests at the reset capacity; a typed result where obvious
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_REPORT,     32'sd0,          1'b1, EMPTY_OK},
    '{OP_POP_FRONT,  32'sh1357_9BDF,  1'b1, EMPTY_FAIL},
    '{OP_POP_REAR,   32'sd0,          1'b1, EMPTY_FAIL},
    '{OP_PUSH_FRONT, WORD_MAX,        1'b1, ONE_MAX},
    '{OP_PUSH_REAR,  WORD_MIN,        1'b1, MAX_AND_MIN},
    '{OP_PUSH_FRONT, -32'sd1,         1'b0, NO_WANT},
    '{OP_PUSH_REAR,  32'sd0,          1'b0, NO_WANT},
    '{OP_PUSH_FRONT, 32'sh5555_5555,  1'b0, NO_WANT},
    '{OP_PUSH_REAR,  32'shAAAA_AAAA,  1'b0, NO_WANT},
    '{OP_SPARE_5,    32'shDEAD_BEEF,  1'b0, NO_WANT},
    '{OP_SPARE_6,    32'sd0,          1'b0, NO_WANT},
    '{OP_SPARE_7,    -32'sd1,         1'b0, NO_WANT},
    '{OP_POP_REAR,   32'sd0,          1'b0, NO_WANT},
    '{OP_POP_FRONT,  -32'sd1,         1'b0, NO_WANT},
    '{OP_POP_FRONT,  32'sd0,          1'b0, NO_WANT},
    '{OP_POP_REAR,   32'sd0,          1'b0, NO_WANT},
    '{OP_POP_REAR,   32'sd0,          1'b0, NO_WANT},
    '{OP_POP_FRONT,  32'sd0,          1'b1, EMPTY_OK},
    '{OP_POP_FRONT,  32'sd0,          1'b1, EMPTY_FAIL},
    '{OP_PUSH_REAR,  32'sh0F0F_0F0F,  1'b0, NO_WANT},
    '{OP_PUSH_FRONT, 32'shF0F0_F0F0,  1'b0, NO_WANT},
    '{OP_REPORT,     32'sh7777_0000,  1'b0, NO_WANT},
    '{OP_POP_FRONT,  32'sd0,          1'b0, NO_WANT},
    '{OP_POP_REAR,   32'sd0,          1'b1, EMPTY_OK}
  };

  // Capacity and push share of each random phase
  int phase_caps [PHASES]     = '{16, 4, 0, 1, 31, 17, 2, 16, CAP_RANDOM, 9, 16, CAP_RANDOM};
  int phase_push_pct [PHASES] = '{65, 35, 50, 55, 70, 30, 50, 75, 50, 40, 25, 60};

  logic [OP_W-1:0]           spare_codes [3]  = '{OP_SPARE_5, OP_SPARE_6, OP_SPARE_7};
  logic signed [VALUE_W-1:0] corner_words [4] = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1};

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_double_ended_queue_top #(
    .DEPTH (RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the deque and its capacity register
  logic signed [VALUE_W-1:0] shadow_ring [RING_DEPTH];
  logic [IDX_W-1:0]          shadow_head;
  logic [CNT_W-1:0]          shadow_count;
  logic [CNT_W-1:0]          shadow_cap;

  deque_status_t predicted_status [$];
  deque_status_t got_status;

  bit               steady_run;
  bit               hold_off_req;
  int               stall_left;
  int               cycle_count;
  int               mismatches;
  int               results_checked;
  int               requests_sent;
  int               refused_requests;
  int               cap_writes;
  logic [CNT_W-1:0] next_cap;

  // Apply one request to the shadow deque and return the status it leaves
  function automatic deque_status_t apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] word);
    deque_status_t    status;
    logic [CNT_W-1:0] limit;
    logic             full;
    logic [IDX_W-1:0] slot;
    limit = (shadow_cap > RING_DEPTH) ? CNT_W'(RING_DEPTH) : shadow_cap;
    full = (shadow_count >= limit);
    status.ok = 1'b1;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status.ok = 1'b0;
        end else begin
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = word;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          status.ok = 1'b0;
        end else begin
          slot = shadow_head + shadow_count[IDX_W-1:0];
          shadow_ring[slot] = word;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          status.ok = 1'b0;
        end else begin
          shadow_count = shadow_count - 1'b1;
          // front index stays put when the queue drains
          if (shadow_count != 0) shadow_head = shadow_head + 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (shadow_count == 0) status.ok = 1'b0;
        else shadow_count = shadow_count - 1'b1;
      end
      default: begin
      end
    endcase
    status.front_value = EMPTY_WORD;
    status.rear_value  = EMPTY_WORD;
    if (shadow_count != 0) begin
      slot = shadow_head + shadow_count[IDX_W-1:0] - 1'b1;
      status.front_value = shadow_ring[shadow_head];
      status.rear_value  = shadow_ring[slot];
    end
    status.is_empty    = (shadow_count == 0);
    status.is_full     = (shadow_count >= limit);
    status.entry_total = shadow_count;
    return status;
  endfunction

  // Compare one arrived result with its prediction
  task automatic check_status(input deque_status_t got, input deque_status_t want);
    if (got.ok !== want.ok) begin
      $error("ok: expected %0d, actual %0d", want.ok, got.ok);
      mismatches++;
    end
    if (got.front_value !== want.front_value) begin
      $error("front_value: expected %0d, actual %0d", want.front_value, got.front_value);
      mismatches++;
    end
    if (got.rear_value !== want.rear_value) begin
      $error("rear_value: expected %0d, actual %0d", want.rear_value, got.rear_value);
      mismatches++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
      mismatches++;
    end
    if (got.is_full !== want.is_full) begin
      $error("is_full: expected %0d, actual %0d", want.is_full, got.is_full);
      mismatches++;
    end
    if (got.entry_total !== want.entry_total) begin
      $error("entry_total: expected %0d, actual %0d", want.entry_total, got.entry_total);
      mismatches++;
    end
  endtask

  // Offer one request, hold it until accepted, then record its prediction
  task automatic issue_request(input logic [OP_W-1:0] op,
                               input logic signed [VALUE_W-1:0] word,
                               input logic has_want, input deque_status_t want);
    deque_status_t predicted;
    if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= word;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = apply_deque_op(op, word);
    predicted_status.push_back(has_want ? want : predicted);
    requests_sent++;
    if (!predicted.ok) refused_requests++;
  endtask

  // Build a random request: mostly pushes and pops, some reports and spare codes
  task automatic random_request(input int push_pct);
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] word;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 5) op = OP_REPORT;
    else if (pick < 8) op = spare_codes[$urandom_range(2)];
    else if ($urandom_range(99) < push_pct) op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    else op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
    word = ($urandom_range(9) == 0) ? corner_words[$urandom_range(3)] : $urandom;
    issue_request(op, word, 1'b0, NO_WANT);
  endtask

  // Drain, let the block settle, then write the capacity register
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap = cap;
    cap_writes++;
  endtask

  // Result side: check each accepted result, drive ready with stalls
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got_status = '{rsp_ch.ok, rsp_ch.front_value, rsp_ch.rear_value,
                       rsp_ch.is_empty, rsp_ch.is_full, rsp_ch.entry_total};
        if (predicted_status.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          check_status(got_status, predicted_status.pop_front());
          results_checked++;
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      // hold off for a long stretch so the block backs up into its input
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, predicted_status.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Request side: reset, directed table, random phases, drain and verdict
  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.op     <= OP_REPORT;
    req_ch.value  <= '0;
    shadow_head   = '0;
    shadow_count  = '0;
    shadow_cap    = CNT_W'(16);
    for (int i = 0; i < RING_DEPTH; i++) shadow_ring[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_request(directed_rows[i].op, directed_rows[i].value,
                    directed_rows[i].has_want, directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      next_cap = (phase_caps[p] == CAP_RANDOM) ? CNT_W'($urandom_range(31))
                                                : CNT_W'(phase_caps[p]);
      set_capacity(next_cap);
      steady_run = (p == STEADY_PHASE);
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(phase_push_pct[p]);
    end

    req_ch.valid <= 1'b0;
    steady_run = 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("Covered %0d requests (%0d directed) over %0d capacity settings, %0d results checked.",
             requests_sent, DIRECTED_ROWS, cap_writes, results_checked);
    $display("%0d requests were refused as push on full or pop on empty.", refused_requests);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
